FILE: rtl/core/ahs_pkg.sv
// Shared types and constants for the axis homing sequencer.
package ahs_pkg;

    // Field widths of the stream words and registers
    localparam int POS_W      = 12;
    localparam int RAMP_W     = 16;
    localparam int RAMP_FRAC  = 8;
    localparam int TICK_W     = 20;
    localparam int PAUSE_W    = 16;
    localparam int SP_OUT_W   = 20;
    localparam int SP_W       = 40;
    localparam int PHASE_W    = 3;
    localparam int EVENT_W    = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Homing phases, encoded as reported on the result word
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE         = 3'd0,
        PH_SEEK_LOWER   = 3'd1,
        PH_SETTLE_LOWER = 3'd2,
        PH_SEEK_UPPER   = 3'd3,
        PH_SETTLE_UPPER = 3'd4,
        PH_APPROACH     = 3'd5,
        PH_HOLD         = 3'd6
    } t_phase;

    // Event codes on the result word
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE    = 2'd0,
        EV_DONE    = 2'd1,
        EV_TIMEOUT = 2'd2
    } t_event;

    // Register indexes (byte address is four times the index)
    localparam logic [REG_IDX_W-1:0] REG_RAMP_STEP       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ARRIVE_DISTANCE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS      = 3'd4;

    // Register reset values
    localparam logic [RAMP_W-1:0]  RST_RAMP_STEP       = 16'd26;
    localparam logic [TICK_W-1:0]  RST_TIMEOUT_TICKS   = 20'd10000;
    localparam logic [POS_W-1:0]   RST_ARRIVE_DISTANCE = 12'd40;
    localparam logic [PAUSE_W-1:0] RST_SETTLE_TICKS    = 16'd1000;
    localparam logic [PAUSE_W-1:0] RST_HOLD_TICKS      = 16'd500;

    // Configuration seen by the sequencer core
    typedef struct packed {
        logic [RAMP_W-1:0]  ramp_step;
        logic [TICK_W-1:0]  timeout_ticks;
        logic [POS_W-1:0]   arrive_distance;
        logic [PAUSE_W-1:0] settle_ticks;
        logic [PAUSE_W-1:0] hold_ticks;
    } t_cfg;

endpackage

FILE: rtl/core/ahs_cfg_regs.sv
// APB register bank holding the homing configuration.
module ahs_cfg_regs
    import ahs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [RAMP_W-1:0]    r_ramp_step;
    logic [TICK_W-1:0]    r_timeout_ticks;
    logic [POS_W-1:0]     r_arrive_distance;
    logic [PAUSE_W-1:0]   r_settle_ticks;
    logic [PAUSE_W-1:0]   r_hold_ticks;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite & pready;

    // Write the addressed register in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step       <= RST_RAMP_STEP;
            r_timeout_ticks   <= RST_TIMEOUT_TICKS;
            r_arrive_distance <= RST_ARRIVE_DISTANCE;
            r_settle_ticks    <= RST_SETTLE_TICKS;
            r_hold_ticks      <= RST_HOLD_TICKS;
        end else if (w_wr) begin
            case (w_idx)
                REG_RAMP_STEP:       r_ramp_step       <= pwdata[RAMP_W-1:0];
                REG_TIMEOUT_TICKS:   r_timeout_ticks   <= pwdata[TICK_W-1:0];
                REG_ARRIVE_DISTANCE: r_arrive_distance <= pwdata[POS_W-1:0];
                REG_SETTLE_TICKS:    r_settle_ticks    <= pwdata[PAUSE_W-1:0];
                REG_HOLD_TICKS:      r_hold_ticks      <= pwdata[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            REG_RAMP_STEP:       prdata = APB_DATA_W'(r_ramp_step);
            REG_TIMEOUT_TICKS:   prdata = APB_DATA_W'(r_timeout_ticks);
            REG_ARRIVE_DISTANCE: prdata = APB_DATA_W'(r_arrive_distance);
            REG_SETTLE_TICKS:    prdata = APB_DATA_W'(r_settle_ticks);
            REG_HOLD_TICKS:      prdata = APB_DATA_W'(r_hold_ticks);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.ramp_step       = r_ramp_step;
    assign o_cfg.timeout_ticks   = r_timeout_ticks;
    assign o_cfg.arrive_distance = r_arrive_distance;
    assign o_cfg.settle_ticks    = r_settle_ticks;
    assign o_cfg.hold_ticks      = r_hold_ticks;

endmodule

FILE: rtl/core/ahs_midpoint.sv
// Wrapped midpoint of the two captured switch angles, in setpoint fixed point.
module ahs_midpoint
    import ahs_pkg::*;
#(
    parameter int ANGLE_MODULUS = 4095,
    parameter int FRACTION_BITS = 8
) (
    input  logic [POS_W-1:0] i_lower,
    input  logic [POS_W-1:0] i_upper,
    output logic [((POS_W + FRACTION_BITS) > ($clog2(ANGLE_MODULUS + 1) + FRACTION_BITS)
                   ? (POS_W + FRACTION_BITS)
                   : ($clog2(ANGLE_MODULUS + 1) + FRACTION_BITS))-1:0] o_midpoint
);

    localparam int MOD_W  = $clog2(ANGLE_MODULUS + 1);
    localparam int MFIX_W = MOD_W + FRACTION_BITS;
    localparam int PFIX_W = POS_W + FRACTION_BITS;
    localparam int MID_W  = (PFIX_W > MFIX_W) ? PFIX_W : MFIX_W;
    // Largest quotient of the wrapped sum by the modulus, plus margin
    localparam int QMAX   = (2 * ((1 << POS_W) - 1) + ANGLE_MODULUS) / (2 * ANGLE_MODULUS) + 1;
    localparam int NSTEP  = $clog2(QMAX + 1);
    localparam int W      = MID_W + NSTEP + 2;
    localparam logic [W-1:0] MOD_FIX = W'(ANGLE_MODULUS) << FRACTION_BITS;

    logic [PFIX_W-1:0]   w_lo_fix;
    logic [PFIX_W-1:0]   w_hi_fix;
    logic [PFIX_W:0]     w_sum;
    logic signed [W-1:0] w_lo;
    logic signed [W-1:0] w_hi;
    logic signed [W-1:0] w_d;
    logic signed [W-1:0] w_q;
    logic signed [W-1:0] w_v;
    logic [W-1:0]        w_r;

    assign w_lo_fix = {i_lower, {FRACTION_BITS{1'b0}}};
    assign w_hi_fix = {i_upper, {FRACTION_BITS{1'b0}}};
    assign w_sum    = {1'b0, w_lo_fix} + {1'b0, w_hi_fix};
    assign w_lo     = W'(w_lo_fix);
    assign w_hi     = W'(w_hi_fix);

    // Half the wrapped span, truncated toward zero; the sum is never negative
    assign w_d = $signed(MOD_FIX) + w_hi - w_lo;
    assign w_q = w_d[W-1] ? -((-w_d) >>> 1) : (w_d >>> 1);
    assign w_v = w_lo + w_q;

    // Reduce modulo the angle span by restoring subtraction of scaled moduli
    always_comb begin
        w_r = w_v;
        for (int k = NSTEP - 1; k >= 0; k--) begin
            if (w_r >= (MOD_FIX << k)) begin
                w_r = w_r - (MOD_FIX << k);
            end
        end
    end

    assign o_midpoint = (i_lower < i_upper) ? MID_W'(w_sum >> 1) : MID_W'(w_r);

endmodule

FILE: rtl/core/axis_homing_sequencer.sv
// Homing sequencer for one rotary axis, one stream word per control tick.
//
//  channel   dir  word fields (lsb first)                                   accept
//  s_axis    in   position[11:0] lower_switch upper_switch start_req        tvalid & tready
//  m_axis    out  armed setpoint[19:0] lower_limit upper_limit              tvalid & tready
//                 limits_valid phase[2:0] event_res[1:0]
//  apb       in   ramp_step, timeout_ticks, arrive_distance, settle_ticks,  psel & penable
//                 hold_ticks at byte addresses 0x0 to 0x10                  & pwrite
//
// Each accepted word updates the state registers and its result word is registered
// for the next cycle; a word can be taken every clock while the result register is free or being drained.
// The ramp add/wrap and the midpoint reduction are combinational logic after
// the state registers, in front of the result register.
// s_axis_tready drops only while a result word waits and m_axis_tready is low.
// Synchronous reset returns to idle with no limits committed.
module axis_homing_sequencer
    import ahs_pkg::*;
#(
    parameter int ANGLE_MODULUS = 4095,
    parameter int FRACTION_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // position[11:0], lower_switch[12], upper_switch[13], start_req[14], zero[15]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // armed[0], setpoint[20:1], lower_limit[32:21], upper_limit[44:33],
    // limits_valid[45], phase[48:46], event_res[50:49], zero[55:51]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int MOD_W  = $clog2(ANGLE_MODULUS + 1);
    localparam int MFIX_W = MOD_W + FRACTION_BITS;
    localparam int PFIX_W = POS_W + FRACTION_BITS;
    localparam int MID_W  = (PFIX_W > MFIX_W) ? PFIX_W : MFIX_W;
    localparam int SHW    = RAMP_W + FRACTION_BITS;
    localparam int STEP_W = SHW - RAMP_FRAC;
    localparam int SPX_W  = SP_W + 1;
    localparam int RES_W  = 1 + SP_OUT_W + POS_W + POS_W + 1 + PHASE_W + EVENT_W;
    localparam logic [SPX_W-1:0] MOD_FIX = SPX_W'(ANGLE_MODULUS) << FRACTION_BITS;

    t_cfg                    cfg;
    t_phase                  r_phase, n_phase;
    t_event                  n_event;
    logic [SP_W-1:0]         r_setpoint, n_setpoint;
    logic [POS_W-1:0]        r_cap_lower, n_cap_lower;
    logic [POS_W-1:0]        r_cap_upper, n_cap_upper;
    logic [MID_W-1:0]        r_midpoint, n_midpoint;
    logic [TICK_W-1:0]       r_elapsed, n_elapsed;
    logic [PAUSE_W-1:0]      r_pause, n_pause;
    logic [POS_W-1:0]        r_com_lower, n_com_lower;
    logic [POS_W-1:0]        r_com_upper, n_com_upper;
    logic                    r_valid_flag, n_valid_flag;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;

    logic                    s_fire;
    logic [POS_W-1:0]        in_position;
    logic                    in_lower_sw;
    logic                    in_upper_sw;
    logic                    in_start;
    logic [SHW-1:0]          w_ramp_sh;
    logic [STEP_W-1:0]       w_step;
    logic [SP_W-1:0]         w_sp_down;
    logic [SPX_W-1:0]        w_sp_wrap;
    logic [SPX_W-1:0]        w_sp_up_sum;
    logic [SP_W-1:0]         w_sp_up;
    logic [MID_W-1:0]        w_mid_calc;
    logic [MID_W-1:0]        w_pos_fix;
    logic [MID_W-1:0]        w_dist;
    logic [MID_W-1:0]        w_arrive_fix;
    logic                    w_arrived;
    logic [TICK_W-1:0]       w_elapsed_inc;
    logic                    w_timed_out;
    logic [RES_W-1:0]        w_result;

    ahs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ahs_midpoint #(
        .ANGLE_MODULUS (ANGLE_MODULUS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_midpoint (
        .i_lower    (r_cap_lower),
        .i_upper    (r_cap_upper),
        .o_midpoint (w_mid_calc)
    );

    // Take a word whenever the result register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_position = s_axis_tdata[POS_W-1:0];
    assign in_lower_sw = s_axis_tdata[POS_W];
    assign in_upper_sw = s_axis_tdata[POS_W+1];
    assign in_start    = s_axis_tdata[POS_W+2];

    // Align the 8.8 ramp step to the setpoint fraction
    assign w_ramp_sh = SHW'(cfg.ramp_step) << FRACTION_BITS;
    assign w_step    = w_ramp_sh[SHW-1:RAMP_FRAC];

    // Downward ramp: wrap through the modulus, saturate at zero
    assign w_sp_wrap = {1'b0, r_setpoint} + MOD_FIX;
    always_comb begin
        if (r_setpoint >= SP_W'(w_step)) begin
            w_sp_down = r_setpoint - SP_W'(w_step);
        end else if (w_sp_wrap >= SPX_W'(w_step)) begin
            w_sp_down = SP_W'(w_sp_wrap - SPX_W'(w_step));
        end else begin
            w_sp_down = '0;
        end
    end

    // Upward ramp: subtract the modulus once past the top
    assign w_sp_up_sum = {1'b0, r_setpoint} + SPX_W'(w_step);
    assign w_sp_up     = (w_sp_up_sum <= MOD_FIX) ? SP_W'(w_sp_up_sum)
                                                  : SP_W'(w_sp_up_sum - MOD_FIX);

    // Arrival test against the midpoint
    assign w_pos_fix    = MID_W'({in_position, {FRACTION_BITS{1'b0}}});
    assign w_arrive_fix = MID_W'({cfg.arrive_distance, {FRACTION_BITS{1'b0}}});
    assign w_dist       = (w_pos_fix >= r_midpoint) ? (w_pos_fix - r_midpoint)
                                                    : (r_midpoint - w_pos_fix);
    assign w_arrived    = w_dist < w_arrive_fix;

    // Saturating tick count and timeout compare
    assign w_elapsed_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_timed_out   = w_elapsed_inc >= cfg.timeout_ticks;

    // Next state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_event      = EV_NONE;
        n_setpoint   = r_setpoint;
        n_cap_lower  = r_cap_lower;
        n_cap_upper  = r_cap_upper;
        n_midpoint   = r_midpoint;
        n_elapsed    = r_elapsed;
        n_pause      = r_pause;
        n_com_lower  = r_com_lower;
        n_com_upper  = r_com_upper;
        n_valid_flag = r_valid_flag;
        case (r_phase)
            PH_SEEK_LOWER: begin
                n_elapsed = w_elapsed_inc;
                if (w_timed_out) begin
                    n_phase = PH_IDLE;
                    n_event = EV_TIMEOUT;
                end else if (in_lower_sw) begin
                    n_cap_lower = in_position;
                    n_pause     = '0;
                    n_phase     = PH_SETTLE_LOWER;
                end else begin
                    n_setpoint = w_sp_down;
                end
            end
            PH_SEEK_UPPER: begin
                n_elapsed = w_elapsed_inc;
                if (w_timed_out) begin
                    n_phase = PH_IDLE;
                    n_event = EV_TIMEOUT;
                end else if (in_upper_sw) begin
                    n_cap_upper = in_position;
                    n_pause     = '0;
                    n_phase     = PH_SETTLE_UPPER;
                end else begin
                    n_setpoint = w_sp_up;
                end
            end
            PH_SETTLE_LOWER, PH_SETTLE_UPPER: begin
                n_elapsed = w_elapsed_inc;
                if (r_pause >= cfg.settle_ticks) begin
                    n_pause = '0;
                    if (r_phase == PH_SETTLE_LOWER) begin
                        n_phase = PH_SEEK_UPPER;
                    end else begin
                        n_midpoint = w_mid_calc;
                        n_setpoint = SP_W'(w_mid_calc);
                        n_phase    = PH_APPROACH;
                    end
                end else begin
                    n_pause = r_pause + 1'b1;
                end
            end
            PH_APPROACH: begin
                n_elapsed = w_elapsed_inc;
                if (w_timed_out) begin
                    n_phase = PH_IDLE;
                    n_event = EV_TIMEOUT;
                end else if (w_arrived) begin
                    n_com_lower  = r_cap_lower;
                    n_com_upper  = r_cap_upper;
                    n_valid_flag = 1'b1;
                    n_pause      = '0;
                    n_phase      = PH_HOLD;
                end
            end
            PH_HOLD: begin
                n_elapsed = w_elapsed_inc;
                if (r_pause >= cfg.hold_ticks) begin
                    n_phase = PH_IDLE;
                    n_event = EV_DONE;
                end else begin
                    n_pause = r_pause + 1'b1;
                end
            end
            default: begin
                // Idle: arm on a start request
                n_phase = PH_IDLE;
                if (in_start) begin
                    n_setpoint = SP_W'({in_position, {FRACTION_BITS{1'b0}}});
                    n_elapsed  = '0;
                    n_pause    = '0;
                    n_phase    = PH_SEEK_LOWER;
                end
            end
        endcase
    end

    // Advance the sequencer state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_setpoint   <= '0;
            r_cap_lower  <= '0;
            r_cap_upper  <= '0;
            r_midpoint   <= '0;
            r_elapsed    <= '0;
            r_pause      <= '0;
            r_com_lower  <= '0;
            r_com_upper  <= '0;
            r_valid_flag <= 1'b0;
        end else if (s_fire) begin
            r_phase      <= n_phase;
            r_setpoint   <= n_setpoint;
            r_cap_lower  <= n_cap_lower;
            r_cap_upper  <= n_cap_upper;
            r_midpoint   <= n_midpoint;
            r_elapsed    <= n_elapsed;
            r_pause      <= n_pause;
            r_com_lower  <= n_com_lower;
            r_com_upper  <= n_com_upper;
            r_valid_flag <= n_valid_flag;
        end
    end

    // Pack the result word from the updated state
    assign w_result = {n_event, n_phase, n_valid_flag, n_com_upper, n_com_lower,
                       n_setpoint[SP_OUT_W-1:0], (n_phase != PH_IDLE)};

    // Hold the result word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= OUT_TDATA_W'(w_result);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Committed limits never drop once set
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_flag |=> r_valid_flag)
        else $error("limits_valid cleared after commit");

    // Hold is only reached with committed limits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HOLD) |-> r_valid_flag)
        else $error("hold phase without committed limits");

    // A run starts with a cleared tick count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_SEEK_LOWER) && ($past(r_phase) == PH_IDLE) && $past(i_rst_n))
        |-> (r_elapsed == '0))
        else $error("elapsed count not cleared at start");

endmodule
